// ===== src/foreground_bounding_box_assert.svh =====
// assertion macros for the foreground bounding box block
// used by foreground_bounding_box.sv, no other dependencies
`ifndef FOREGROUND_BOUNDING_BOX_ASSERT_SVH
`define FOREGROUND_BOUNDING_BOX_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbb same-cycle check failed");

// next-cycle implication, disabled in reset
`define FBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbb next-cycle check failed");

`endif

// ===== src/fbb_pkg.sv =====
// shared constants, types and helpers for the foreground bounding box block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package fbb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    localparam int MIN_SIZE      = 5;
    localparam int CORNER        = 5;
    localparam int CORNER_BLOCKS = 4;
    localparam int PAD_MIN       = 2;
    localparam int PAD_DIV       = 10;
    localparam int BG_DIV        = CORNER_BLOCKS * CORNER * CORNER;

    localparam int DEF_WIDTH     = 256;
    localparam int DEF_HEIGHT    = 256;
    localparam int DEF_THRESHOLD = 30;

    localparam int PIX_W      = 8;
    localparam int OUT_W      = 8;
    localparam int SIZE_W     = 9;
    localparam int THR_W      = 8;
    localparam int REG_IDX_W  = 2;
    localparam int REG_DATA_W = 9;

    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int COORD_W = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int DIM_W   = COORD_W + 1;
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int STORE_DEPTH = 1 << ADDR_W;

    localparam int CORNER_CNT_W = $clog2(CORNER);
    localparam int BLK_W        = $clog2(CORNER_BLOCKS);
    localparam int SUM_W        = $clog2(BG_DIV * ((1 << PIX_W) - 1) + 1);

    // divide by constants through reciprocal multiply
    localparam int BG_SHIFT   = 19;
    localparam int BG_RECIP   = ((1 << BG_SHIFT) + BG_DIV - 1) / BG_DIV;
    localparam int BG_RECIP_W = $clog2(BG_RECIP + 1);
    localparam int BG_PROD_W  = SUM_W + BG_RECIP_W;

    localparam int PAD_SHIFT  = 16;
    localparam int PAD_RECIP  = ((1 << PAD_SHIFT) + PAD_DIV - 1) / PAD_DIV;
    localparam int PAD_PROD_W = PAD_SHIFT + DIM_W;

    localparam logic [REG_IDX_W-1:0] REG_FRAME_WIDTH  = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_FG_THRESHOLD = REG_IDX_W'(2);

    typedef logic [PIX_W-1:0]      pixel_t;
    typedef logic [OUT_W-1:0]      out_coord_t;
    typedef logic [SIZE_W-1:0]     cfg_size_t;
    typedef logic [THR_W-1:0]      thr_t;
    typedef logic [REG_IDX_W-1:0]  reg_idx_t;
    typedef logic [REG_DATA_W-1:0] reg_data_t;
    typedef logic [COORD_W-1:0]    coord_t;
    typedef logic [DIM_W-1:0]      dim_t;
    typedef logic [ADDR_W-1:0]     addr_t;
    typedef logic [SUM_W-1:0]      sum_t;

    typedef struct packed {
        dim_t width;
        dim_t height;
        thr_t threshold;
    } frame_cfg_t;

    typedef struct packed {
        logic  en;
        addr_t addr;
    } mem_rd_t;

    typedef struct packed {
        logic   found;
        coord_t min_x;
        coord_t min_y;
        coord_t max_x;
        coord_t max_y;
    } box_t;

    typedef struct packed {
        logic done;
        box_t box;
    } scan_status_t;

    typedef struct packed {
        out_coord_t left;
        out_coord_t top;
        out_coord_t right;
        out_coord_t bottom;
        logic       found;
    } result_t;

    function automatic addr_t store_addr(coord_t x, coord_t y);
        return {y[ROW_W-1:0], x[COL_W-1:0]};
    endfunction

    function automatic dim_t clamp_size(cfg_size_t v, int maxv);
        if (v < SIZE_W'(MIN_SIZE))
            return DIM_W'(MIN_SIZE);
        if (int'(v) > maxv)
            return DIM_W'(maxv);
        return DIM_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== src/fbb_pixel_if.sv =====
// pixel request channel
// depends on fbb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fbb_pixel_if;
    import fbb_pkg::*;

    logic   valid;
    logic   ready;
    pixel_t pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

`default_nettype wire

// ===== src/fbb_result_if.sv =====
// result request channel, one padded box per frame
// depends on fbb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fbb_result_if;
    import fbb_pkg::*;

    logic       valid;
    logic       ready;
    out_coord_t left;
    out_coord_t top;
    out_coord_t right;
    out_coord_t bottom;
    logic       found;

    modport source (output valid, output left, output top, output right, output bottom,
                    output found, input ready);
    modport sink   (input valid, input left, input top, input right, input bottom,
                    input found, output ready);
endinterface

`default_nettype wire

// ===== src/fbb_cfg_if.sv =====
// configuration write channel
// depends on fbb_pkg
`timescale 1ns / 1ps
`default_nettype none

interface fbb_cfg_if;
    import fbb_pkg::*;

    logic      valid;
    logic      ready;
    reg_idx_t  index;
    reg_data_t data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/foreground_bounding_box.sv =====
// top level: configuration, pixel intake into the frame store, result register
// depends on fbb_pkg, the fbb_*_if interfaces, fbb_store, fbb_scan, fbb_pad
// and foreground_bounding_box_assert.svh
//
//   channel   dir   payload                           request when
//   cfg       in    index, data                       valid & ready
//   pixels    in    pixel                             valid & ready
//   result    out   left, top, right, bottom, found   valid & ready
//
// one cycle per pixel while a frame loads into the frame store
// after the last pixel the single read port of the store serves
//   100 corner reads, then width*height scan reads
// pixels and cfg are stalled outside T_LOAD; T_EMIT lasts while an older result waits
// rst_n clears control state and restores the default configuration, the frame store needs no clearing
`timescale 1ns / 1ps
`default_nettype none
`include "foreground_bounding_box_assert.svh"

module foreground_bounding_box (
    input  wire logic    clk,
    input  wire logic    rst_n,
    fbb_cfg_if.sink      cfg,
    fbb_pixel_if.sink    pixels,
    fbb_result_if.source result
);
    import fbb_pkg::*;

    typedef enum logic [3:0] {
        T_LOAD = 4'b0001,
        T_SCAN = 4'b0010,
        T_PAD  = 4'b0100,
        T_EMIT = 4'b1000
    } top_state_t;

    top_state_t state_reg, state_next;

    cfg_size_t width_cfg_reg;
    cfg_size_t height_cfg_reg;
    thr_t      thr_reg;
    coord_t    col_reg, col_next;
    coord_t    row_reg, row_next;
    logic      res_valid_reg, res_valid_next;
    result_t   res_reg;

    dim_t         frame_w;
    dim_t         frame_h;
    frame_cfg_t   frame_cfg;
    logic         pix_accept;
    logic         cfg_accept;
    logic         wrap;
    coord_t       x_cur;
    coord_t       y_cur;
    logic         col_last;
    logic         row_last;
    logic         frame_end;
    logic         res_load;
    mem_rd_t      store_rd;
    pixel_t       store_rd_data;
    scan_status_t scan_status;
    logic         pad_valid;
    result_t      pad_res;

    assign frame_w   = clamp_size(width_cfg_reg, MAX_WIDTH);
    assign frame_h   = clamp_size(height_cfg_reg, MAX_HEIGHT);
    assign frame_cfg = '{width: frame_w, height: frame_h, threshold: thr_reg};

    assign pixels.ready = (state_reg == T_LOAD);
    assign cfg.ready    = (state_reg == T_LOAD);
    assign pix_accept   = pixels.valid && pixels.ready;
    assign cfg_accept   = cfg.valid && cfg.ready;

    assign wrap      = ({1'b0, col_reg} >= frame_w) || ({1'b0, row_reg} >= frame_h);
    assign x_cur     = wrap ? '0 : col_reg;
    assign y_cur     = wrap ? '0 : row_reg;
    assign col_last  = ({1'b0, x_cur} + DIM_W'(1)) >= frame_w;
    assign row_last  = ({1'b0, y_cur} + DIM_W'(1)) >= frame_h;
    assign frame_end = pix_accept && col_last && row_last;

    assign res_load = (state_reg == T_EMIT) && (!res_valid_reg || result.ready);

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (pix_accept)
        begin
            if (!col_last)
            begin
                col_next = x_cur + COORD_W'(1);
                row_next = y_cur;
            end
            else if (!row_last)
            begin
                col_next = '0;
                row_next = y_cur + COORD_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = '0;
            end
        end
        // a size change restarts the frame
        if (cfg_accept && (cfg.index == REG_FRAME_WIDTH || cfg.index == REG_FRAME_HEIGHT))
        begin
            col_next = '0;
            row_next = '0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            T_LOAD:
            begin
                if (frame_end)
                    state_next = T_SCAN;
            end
            T_SCAN:
            begin
                if (scan_status.done)
                    state_next = T_PAD;
            end
            T_PAD:
            begin
                if (pad_valid)
                    state_next = T_EMIT;
            end
            T_EMIT:
            begin
                if (res_load)
                    state_next = T_LOAD;
            end
            default:
            begin
                state_next = T_LOAD;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_load)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= T_LOAD;
            width_cfg_reg  <= SIZE_W'(DEF_WIDTH);
            height_cfg_reg <= SIZE_W'(DEF_HEIGHT);
            thr_reg        <= THR_W'(DEF_THRESHOLD);
            col_reg        <= '0;
            row_reg        <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            res_valid_reg <= res_valid_next;
            if (cfg_accept)
            begin
                case (cfg.index)
                    REG_FRAME_WIDTH:  width_cfg_reg  <= SIZE_W'(cfg.data);
                    REG_FRAME_HEIGHT: height_cfg_reg <= SIZE_W'(cfg.data);
                    REG_FG_THRESHOLD: thr_reg        <= THR_W'(cfg.data);
                    default:          thr_reg        <= thr_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= pad_res;
        end
    end

    fbb_store u_store (
        .clk     (clk),
        .wr_en   (pix_accept),
        .wr_addr (store_addr(x_cur, y_cur)),
        .wr_data (pixels.pixel),
        .rd      (store_rd),
        .rd_data (store_rd_data)
    );

    fbb_scan u_scan (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (frame_end),
        .cfg     (frame_cfg),
        .rd      (store_rd),
        .rd_data (store_rd_data),
        .status  (scan_status)
    );

    fbb_pad u_pad (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scan_status.done),
        .box   (scan_status.box),
        .cfg   (frame_cfg),
        .valid (pad_valid),
        .res   (pad_res)
    );

    assign result.valid  = res_valid_reg;
    assign result.left   = res_reg.left;
    assign result.top    = res_reg.top;
    assign result.right  = res_reg.right;
    assign result.bottom = res_reg.bottom;
    assign result.found  = res_reg.found;

    `FBB_ASSERT_NEXT(a_frame_end_scans, clk, rst_n, frame_end, state_reg == T_SCAN)
    `FBB_ASSERT_NOW(a_scan_done_in_scan, clk, rst_n, scan_status.done, state_reg == T_SCAN)
    `FBB_ASSERT_NOW(a_pos_in_frame, clk, rst_n, state_reg == T_LOAD, !wrap)
    `FBB_ASSERT_NOW(a_box_ordered, clk, rst_n, result.valid && result.found, (result.left <= result.right) && (result.top <= result.bottom))

endmodule

`default_nettype wire

// ===== src/fbb_store.sv =====
// frame store, one write port and one registered read port
// depends on fbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbb_store (
    input  wire logic            clk,
    input  wire logic            wr_en,
    input  wire fbb_pkg::addr_t  wr_addr,
    input  wire fbb_pkg::pixel_t wr_data,
    input  wire fbb_pkg::mem_rd_t rd,
    output fbb_pkg::pixel_t      rd_data
);
    import fbb_pkg::*;

    pixel_t mem [0:STORE_DEPTH-1];
    pixel_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rd_data_reg <= mem[rd.addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/fbb_scan.sv =====
// read sequencer: corner sum, background level, then foreground box scan
// depends on fbb_pkg, reads through fbb_store
`timescale 1ns / 1ps
`default_nettype none

module fbb_scan (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fbb_pkg::frame_cfg_t cfg,
    output fbb_pkg::mem_rd_t         rd,
    input  wire fbb_pkg::pixel_t     rd_data,
    output fbb_pkg::scan_status_t    status
);
    import fbb_pkg::*;

    typedef enum logic [5:0] {
        SC_IDLE    = 6'b000001,
        SC_CORNER  = 6'b000010,
        SC_SUMWAIT = 6'b000100,
        SC_MEAN    = 6'b001000,
        SC_SCAN    = 6'b010000,
        SC_FLUSH   = 6'b100000
    } scan_state_t;

    scan_state_t state_reg, state_next;

    logic [CORNER_CNT_W-1:0] dx_reg, dx_next;
    logic [CORNER_CNT_W-1:0] dy_reg, dy_next;
    logic [BLK_W-1:0]        blk_reg, blk_next;
    coord_t                  sx_reg, sx_next;
    coord_t                  sy_reg, sy_next;
    logic                    corner_pend_reg, corner_pend_next;
    logic                    scan_pend_reg, scan_pend_next;
    logic                    done_reg, done_next;
    coord_t                  tag_x_reg, tag_x_next;
    coord_t                  tag_y_reg, tag_y_next;
    sum_t                    sum_reg, sum_next;
    logic [BG_PROD_W-1:0]    bg_prod_reg, bg_prod_next;
    box_t                    box_reg, box_next;

    pixel_t bg;
    pixel_t diff;
    logic   is_fg;
    dim_t   base_x;
    dim_t   base_y;
    coord_t cx;
    coord_t cy;
    logic   sx_last;
    logic   sy_last;

    assign bg = bg_prod_reg[BG_SHIFT +: PIX_W];

    always_comb
    begin
        if (rd_data > bg)
            diff = rd_data - bg;
        else
            diff = bg - rd_data;
    end

    assign is_fg = diff > cfg.threshold;

    // corner block origins
    assign base_x = blk_reg[0] ? (cfg.width - DIM_W'(CORNER)) : '0;
    assign base_y = blk_reg[1] ? (cfg.height - DIM_W'(CORNER)) : '0;
    assign cx     = COORD_W'(base_x + DIM_W'(dx_reg));
    assign cy     = COORD_W'(base_y + DIM_W'(dy_reg));

    assign sx_last = ({1'b0, sx_reg} + DIM_W'(1)) == cfg.width;
    assign sy_last = ({1'b0, sy_reg} + DIM_W'(1)) == cfg.height;

    always_comb
    begin
        state_next       = state_reg;
        dx_next          = dx_reg;
        dy_next          = dy_reg;
        blk_next         = blk_reg;
        sx_next          = sx_reg;
        sy_next          = sy_reg;
        corner_pend_next = 1'b0;
        scan_pend_next   = 1'b0;
        done_next        = 1'b0;
        tag_x_next       = sx_reg;
        tag_y_next       = sy_reg;
        sum_next         = sum_reg;
        bg_prod_next     = bg_prod_reg;
        box_next         = box_reg;
        rd.en            = 1'b0;
        rd.addr          = store_addr(sx_reg, sy_reg);

        if (corner_pend_reg)
        begin
            sum_next = sum_reg + SUM_W'(rd_data);
        end

        if (scan_pend_reg && is_fg)
        begin
            box_next.found = 1'b1;
            if (tag_x_reg < box_reg.min_x)
                box_next.min_x = tag_x_reg;
            if (tag_y_reg < box_reg.min_y)
                box_next.min_y = tag_y_reg;
            if (tag_x_reg > box_reg.max_x)
                box_next.max_x = tag_x_reg;
            if (tag_y_reg > box_reg.max_y)
                box_next.max_y = tag_y_reg;
        end

        case (state_reg)
            SC_IDLE:
            begin
                if (start)
                begin
                    dx_next    = '0;
                    dy_next    = '0;
                    blk_next   = '0;
                    sum_next   = '0;
                    state_next = SC_CORNER;
                end
            end
            SC_CORNER:
            begin
                rd.en            = 1'b1;
                rd.addr          = store_addr(cx, cy);
                corner_pend_next = 1'b1;
                if (dx_reg == CORNER_CNT_W'(CORNER - 1))
                begin
                    dx_next = '0;
                    if (dy_reg == CORNER_CNT_W'(CORNER - 1))
                    begin
                        dy_next  = '0;
                        blk_next = blk_reg + BLK_W'(1);
                        if (blk_reg == BLK_W'(CORNER_BLOCKS - 1))
                            state_next = SC_SUMWAIT;
                    end
                    else
                    begin
                        dy_next = dy_reg + CORNER_CNT_W'(1);
                    end
                end
                else
                begin
                    dx_next = dx_reg + CORNER_CNT_W'(1);
                end
            end
            SC_SUMWAIT:
            begin
                state_next = SC_MEAN;
            end
            SC_MEAN:
            begin
                bg_prod_next   = BG_PROD_W'(sum_reg) * BG_PROD_W'(BG_RECIP);
                sx_next        = '0;
                sy_next        = '0;
                box_next.found = 1'b0;
                box_next.min_x = '1;
                box_next.min_y = '1;
                box_next.max_x = '0;
                box_next.max_y = '0;
                state_next     = SC_SCAN;
            end
            SC_SCAN:
            begin
                rd.en          = 1'b1;
                scan_pend_next = 1'b1;
                if (sx_last)
                begin
                    sx_next = '0;
                    sy_next = sy_reg + COORD_W'(1);
                    if (sy_last)
                        state_next = SC_FLUSH;
                end
                else
                begin
                    sx_next = sx_reg + COORD_W'(1);
                end
            end
            SC_FLUSH:
            begin
                done_next  = 1'b1;
                state_next = SC_IDLE;
            end
            default:
            begin
                state_next = SC_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= SC_IDLE;
            corner_pend_reg <= 1'b0;
            scan_pend_reg   <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            corner_pend_reg <= corner_pend_next;
            scan_pend_reg   <= scan_pend_next;
            done_reg        <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        blk_reg     <= blk_next;
        sx_reg      <= sx_next;
        sy_reg      <= sy_next;
        tag_x_reg   <= tag_x_next;
        tag_y_reg   <= tag_y_next;
        sum_reg     <= sum_next;
        bg_prod_reg <= bg_prod_next;
        box_reg     <= box_next;
    end

    assign status.done = done_reg;
    assign status.box  = box_reg;

endmodule

`default_nettype wire

// ===== src/fbb_pad.sv =====
// pads the found box by max(2, extent/10) per axis and clamps it to the frame
// depends on fbb_pkg
`timescale 1ns / 1ps
`default_nettype none

module fbb_pad (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire fbb_pkg::box_t       box,
    input  wire fbb_pkg::frame_cfg_t cfg,
    output logic                     valid,
    output fbb_pkg::result_t         res
);
    import fbb_pkg::*;

    typedef logic [PAD_PROD_W-1:0] pad_prod_t;
    typedef logic [DIM_W:0]        wide_t;

    function automatic dim_t pad_select(pad_prod_t prod);
        dim_t p;
        p = prod[PAD_SHIFT +: DIM_W];
        if (p < DIM_W'(PAD_MIN))
            return DIM_W'(PAD_MIN);
        return p;
    endfunction

    logic      v1_reg;
    logic      valid_reg;
    box_t      box_reg;
    pad_prod_t prod_x_reg;
    pad_prod_t prod_y_reg;
    result_t   res_reg, res_next;

    dim_t  ext_x;
    dim_t  ext_y;
    dim_t  pad_x;
    dim_t  pad_y;
    dim_t  lo_x;
    dim_t  lo_y;
    wide_t hi_x;
    wide_t hi_y;
    wide_t lim_x;
    wide_t lim_y;

    assign ext_x = DIM_W'(box.max_x) - DIM_W'(box.min_x) + DIM_W'(1);
    assign ext_y = DIM_W'(box.max_y) - DIM_W'(box.min_y) + DIM_W'(1);

    assign pad_x = pad_select(prod_x_reg);
    assign pad_y = pad_select(prod_y_reg);
    assign lim_x = (DIM_W + 1)'(cfg.width) - (DIM_W + 1)'(1);
    assign lim_y = (DIM_W + 1)'(cfg.height) - (DIM_W + 1)'(1);

    always_comb
    begin
        lo_x = ({1'b0, box_reg.min_x} > pad_x) ? (DIM_W'(box_reg.min_x) - pad_x) : '0;
        lo_y = ({1'b0, box_reg.min_y} > pad_y) ? (DIM_W'(box_reg.min_y) - pad_y) : '0;
        hi_x = (DIM_W + 1)'(box_reg.max_x) + (DIM_W + 1)'(pad_x);
        hi_y = (DIM_W + 1)'(box_reg.max_y) + (DIM_W + 1)'(pad_y);
        if (hi_x > lim_x)
            hi_x = lim_x;
        if (hi_y > lim_y)
            hi_y = lim_y;

        if (box_reg.found)
        begin
            res_next.left   = OUT_W'(lo_x);
            res_next.top    = OUT_W'(lo_y);
            res_next.right  = OUT_W'(hi_x);
            res_next.bottom = OUT_W'(hi_y);
            res_next.found  = 1'b1;
        end
        else
        begin
            res_next.left   = '0;
            res_next.top    = '0;
            res_next.right  = OUT_W'(lim_x);
            res_next.bottom = OUT_W'(lim_y);
            res_next.found  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg    <= start;
            valid_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            box_reg    <= box;
            prod_x_reg <= PAD_PROD_W'(ext_x) * PAD_PROD_W'(PAD_RECIP);
            prod_y_reg <= PAD_PROD_W'(ext_y) * PAD_PROD_W'(PAD_RECIP);
        end
        if (v1_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign valid = valid_reg;
    assign res   = res_reg;

endmodule

`default_nettype wire

// ===== tb/sv/foreground_bounding_box_test.sv =====
// self-checking testbench for foreground_bounding_box: frames go in as pixel requests,
// each padded box that comes out is checked against a behavioral box predictor or a typed box
// depends on fbb_pkg, fbb_cfg_if, fbb_pixel_if, fbb_result_if and the block itself
`timescale 1ns / 1ps

module foreground_bounding_box_test;
    import fbb_pkg::*;

    localparam reg_idx_t REG_SPARE = REG_IDX_W'(3);

    localparam int SETTLE_CYCLES = 16;
    localparam int TAIL_CYCLES   = 300;
    localparam int HOLD_CYCLES   = 1500;
    localparam int RAND_ITEMS    = 1500;

    typedef enum int {SCENE_BLOB, SCENE_FLAT, SCENE_NOISE} scene_style_t;

    typedef struct packed {
        scene_style_t style;
        int           bg;
        int           fg;
        int           noise;
        int           x0;
        int           y0;
        int           x1;
        int           y1;
    } scene_t;

    typedef struct packed {
        reg_data_t w_val;
        reg_data_t h_val;
        reg_data_t thr_val;
        int        lead;
        scene_t    sc;
        logic      typed;
        result_t   box;
    } probe_t;

    localparam probe_t PROBES [7] = '{
        '{9'd0, 9'd4, 9'd30, 0, '{SCENE_FLAT, 100, 0, 0, 0, 0, 0, 0},
          1'b1, '{8'd0, 8'd0, 8'd4, 8'd4, 1'b0}},
        '{9'd5, 9'd5, 9'd0, 0, '{SCENE_BLOB, 0, 1, 0, 2, 2, 2, 2},
          1'b1, '{8'd0, 8'd0, 8'd4, 8'd4, 1'b1}},
        '{9'd5, 9'd5, 9'd30, 0, '{SCENE_BLOB, 0, 200, 0, 0, 0, 0, 0},
          1'b1, '{8'd0, 8'd0, 8'd2, 8'd2, 1'b1}},
        '{9'd5, 9'd5, 9'd30, 0, '{SCENE_BLOB, 0, 200, 0, 4, 4, 4, 4},
          1'b1, '{8'd2, 8'd2, 8'd4, 8'd4, 1'b1}},
        '{9'd5, 9'd5, 9'h1FF, 0, '{SCENE_BLOB, 0, 255, 0, 1, 1, 3, 3},
          1'b1, '{8'd0, 8'd0, 8'd4, 8'd4, 1'b0}},
        '{9'd5, 9'd5, 9'd0, 0, '{SCENE_FLAT, 255, 0, 0, 0, 0, 0, 0},
          1'b1, '{8'd0, 8'd0, 8'd4, 8'd4, 1'b0}},
        '{9'd12, 9'd9, 9'd30, 7, '{SCENE_BLOB, 40, 220, 6, 5, 3, 7, 5},
          1'b0, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}}
    };

    logic clk = 1'b0;
    logic rst_n;

    fbb_cfg_if    cfg_ch ();
    fbb_pixel_if  pix_ch ();
    fbb_result_if res_ch ();

    foreground_bounding_box dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_ch),
        .pixels (pix_ch),
        .result (res_ch)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    reg_data_t width_reg  = reg_data_t'(DEF_WIDTH);
    reg_data_t height_reg = reg_data_t'(DEF_HEIGHT);
    thr_t      thr_reg    = thr_t'(DEF_THRESHOLD);
    pixel_t    frame_mem [MAX_WIDTH * MAX_HEIGHT];
    int        next_col = 0;
    int        next_row = 0;
    result_t   pending_boxes [$];
    logic      typed_pending = 1'b0;
    result_t   typed_box;

    int  boxes_seen    = 0;
    int  mismatches    = 0;
    int  src_idle_pct  = 13;
    int  snk_idle_pct  = 52;
    bit  hold_request  = 1'b0;

    function automatic int eff_dim(reg_data_t v, int maxv);
        if (v < MIN_SIZE)
            return MIN_SIZE;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic int corner_block(int sx, int sy);
        int acc;
        acc = 0;
        for (int dy = 0; dy < CORNER; dy++)
            for (int dx = 0; dx < CORNER; dx++)
                acc += int'(frame_mem[(sy + dy) * MAX_WIDTH + sx + dx]);
        return acc;
    endfunction

    function automatic int pad_amount(int lo, int hi);
        int p;
        p = (hi - lo + 1) / PAD_DIV;
        return (p < PAD_MIN) ? PAD_MIN : p;
    endfunction

    function automatic result_t predict_box(int w, int h);
        int      bg;
        int      d;
        int      lo_x;
        int      lo_y;
        int      hi_x;
        int      hi_y;
        int      px;
        int      py;
        int      r;
        int      b;
        result_t box;
        bg = (corner_block(0, 0) + corner_block(w - CORNER, 0)
            + corner_block(0, h - CORNER) + corner_block(w - CORNER, h - CORNER)) / BG_DIV;
        lo_x = w;
        lo_y = h;
        hi_x = 0;
        hi_y = 0;
        for (int y = 0; y < h; y++)
            for (int x = 0; x < w; x++)
            begin
                d = int'(frame_mem[y * MAX_WIDTH + x]) - bg;
                if (d < 0)
                    d = -d;
                if (d > int'(thr_reg))
                begin
                    if (x < lo_x) lo_x = x;
                    if (y < lo_y) lo_y = y;
                    if (x > hi_x) hi_x = x;
                    if (y > hi_y) hi_y = y;
                end
            end
        if (lo_x > hi_x || lo_y > hi_y)
        begin
            box = '{8'd0, 8'd0, out_coord_t'(w - 1), out_coord_t'(h - 1), 1'b0};
            return box;
        end
        px = pad_amount(lo_x, hi_x);
        py = pad_amount(lo_y, hi_y);
        r = (hi_x + px > w - 1) ? w - 1 : hi_x + px;
        b = (hi_y + py > h - 1) ? h - 1 : hi_y + py;
        box.left   = out_coord_t'((lo_x > px) ? lo_x - px : 0);
        box.top    = out_coord_t'((lo_y > py) ? lo_y - py : 0);
        box.right  = out_coord_t'(r);
        box.bottom = out_coord_t'(b);
        box.found  = 1'b1;
        return box;
    endfunction

    function automatic void store_pixel(pixel_t p);
        int      w;
        int      h;
        int      x;
        int      y;
        result_t box;
        w = eff_dim(width_reg, MAX_WIDTH);
        h = eff_dim(height_reg, MAX_HEIGHT);
        x = next_col;
        y = next_row;
        if (x >= w || y >= h)
        begin
            x = 0;
            y = 0;
        end
        frame_mem[y * MAX_WIDTH + x] = p;
        if (x + 1 < w)
        begin
            next_col = x + 1;
            next_row = y;
        end
        else if (y + 1 < h)
        begin
            next_col = 0;
            next_row = y + 1;
        end
        else
        begin
            next_col = 0;
            next_row = 0;
            box = predict_box(w, h);
            if (typed_pending)
            begin
                box = typed_box;
                typed_pending = 1'b0;
            end
            pending_boxes.push_back(box);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && cfg_ch.valid && cfg_ch.ready)
        begin
            case (cfg_ch.index)
                REG_FRAME_WIDTH:
                begin
                    width_reg = cfg_ch.data;
                    next_col = 0;
                    next_row = 0;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg = cfg_ch.data;
                    next_col = 0;
                    next_row = 0;
                end
                REG_FG_THRESHOLD:
                    thr_reg = cfg_ch.data[THR_W-1:0];
                default:
                    ;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && pix_ch.valid && pix_ch.ready)
            store_pixel(pix_ch.pixel);
    end

    always @(posedge clk)
    begin : check_boxes
        result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            boxes_seen++;
            if (pending_boxes.size() == 0)
            begin
                $error("box reported with none pending");
                mismatches++;
            end
            else
            begin
                want = pending_boxes.pop_front();
                check_field("left", want.left, res_ch.left);
                check_field("top", want.top, res_ch.top);
                check_field("right", want.right, res_ch.right);
                check_field("bottom", want.bottom, res_ch.bottom);
                check_field("found", want.found, res_ch.found);
            end
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    function automatic pixel_t scene_pixel(scene_t sc, int x, int y);
        int v;
        case (sc.style)
            SCENE_NOISE: v = $urandom_range(255);
            SCENE_FLAT:  v = sc.bg;
            default:
                v = (x >= sc.x0 && x <= sc.x1 && y >= sc.y0 && y <= sc.y1) ? sc.fg : sc.bg;
        endcase
        if (sc.noise > 0)
            v = v + int'($urandom_range(2 * sc.noise)) - sc.noise;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return pixel_t'(v);
    endfunction

    function automatic scene_t random_scene(int w, int h);
        scene_t sc;
        int     pick;
        pick = $urandom_range(9);
        sc.style = (pick < 7) ? SCENE_BLOB : ((pick < 9) ? SCENE_FLAT : SCENE_NOISE);
        sc.bg = $urandom_range(255);
        sc.fg = $urandom_range(255);
        sc.noise = ($urandom_range(2) == 0) ? 0 : $urandom_range(12);
        sc.x0 = $urandom_range(w - 1);
        sc.x1 = $urandom_range(w - 1, sc.x0);
        sc.y0 = $urandom_range(h - 1);
        sc.y1 = $urandom_range(h - 1, sc.y0);
        return sc;
    endfunction

    function automatic reg_data_t pick_dim(int hi_a, int hi_b, int hi_c);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return reg_data_t'($urandom_range(MIN_SIZE - 1));
        if (r < 70)
            return reg_data_t'($urandom_range(hi_a, MIN_SIZE));
        if (r < 92)
            return reg_data_t'($urandom_range(hi_b, hi_a + 1));
        return reg_data_t'($urandom_range(hi_c, hi_b + 1));
    endfunction

    function automatic reg_data_t pick_threshold();
        int r;
        int t;
        r = $urandom_range(99);
        if (r < 10)
            t = 0;
        else if (r < 20)
            t = 255;
        else
            t = $urandom_range(80, 4);
        return {1'($urandom_range(1)), thr_t'(t)};
    endfunction

    task automatic send_pixel(pixel_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= p;
        @(posedge clk);
        while (!pix_ch.ready)
            @(posedge clk);
    endtask

    task automatic send_frame(scene_t sc, int first, int last);
        int w;
        w = eff_dim(width_reg, MAX_WIDTH);
        for (int i = first; i < last; i++)
            send_pixel(scene_pixel(sc, i % w, i / w));
    endtask

    // stop pixel requests and let every pending box come back
    task automatic drain();
        pix_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_boxes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, reg_data_t val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int        w;
        int        h;
        int        n;
        int        phase;
        int        frames;
        int        first;
        int        rand_items;
        bit        midframe;
        bit        resize;
        reg_data_t wval;
        reg_data_t hval;

        rst_n = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_FRAME_WIDTH;
        cfg_ch.data = '0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel = '0;
        res_ch.ready = 1'b0;
        rand_items = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames
        for (int i = 0; i < $size(PROBES); i++)
        begin
            drain();
            for (int k = 0; k < PROBES[i].lead; k++)
                send_pixel(pixel_t'($urandom_range(255)));
            if (PROBES[i].lead > 0)
                drain();
            write_reg(REG_FRAME_WIDTH, PROBES[i].w_val);
            write_reg(REG_FRAME_HEIGHT, PROBES[i].h_val);
            write_reg(REG_FG_THRESHOLD, PROBES[i].thr_val);
            write_reg(REG_SPARE, reg_data_t'($urandom_range(511)));
            typed_box = PROBES[i].box;
            typed_pending = PROBES[i].typed;
            send_frame(PROBES[i].sc, 0,
                       eff_dim(width_reg, MAX_WIDTH) * eff_dim(height_reg, MAX_HEIGHT));
        end

        // random frames
        phase = 0;
        while (rand_items < RAND_ITEMS)
        begin
            if (rand_items < RAND_ITEMS / 3)
            begin
                src_idle_pct = 13;
                snk_idle_pct = 52;
            end
            else if (rand_items < 2 * RAND_ITEMS / 3)
            begin
                src_idle_pct = 52;
                snk_idle_pct = 13;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            drain();
            w = eff_dim(width_reg, MAX_WIDTH);
            h = eff_dim(height_reg, MAX_HEIGHT);
            midframe = (phase % 4 == 1);
            resize = 1'b1;
            // stop partway through a frame, then resize or just retune
            if (midframe)
            begin
                n = $urandom_range((w * h - 1 < 40) ? w * h - 1 : 40, 1);
                send_frame(random_scene(w, h), 0, n);
                rand_items += n;
                drain();
                resize = $urandom_range(1);
            end
            if (resize)
            begin
                case (phase)
                    3:
                    begin
                        wval = 9'd8;
                        hval = 9'd6;
                    end
                    4:
                    begin
                        wval = 9'd2;
                        hval = 9'd3;
                    end
                    default:
                    begin
                        wval = pick_dim(10, 20, 32);
                        hval = pick_dim(8, 16, 24);
                    end
                endcase
                write_reg(REG_FRAME_WIDTH, wval);
                write_reg(REG_FRAME_HEIGHT, hval);
            end
            if (phase == 0 || $urandom_range(2) != 0)
                write_reg(REG_FG_THRESHOLD, pick_threshold());
            if ($urandom_range(7) == 0)
                write_reg(REG_SPARE, reg_data_t'($urandom_range(511)));
            w = eff_dim(width_reg, MAX_WIDTH);
            h = eff_dim(height_reg, MAX_HEIGHT);
            if (phase == 4)
                frames = 1;
            else if (phase == 3)
                frames = 5;
            else
                frames = $urandom_range(4, 1);
            // hold the result side off so the block backs up
            if (phase == 3)
                hold_request = 1'b1;
            for (int f = 0; f < frames && rand_items < RAND_ITEMS; f++)
            begin
                first = (f == 0) ? next_row * w + next_col : 0;
                send_frame(random_scene(w, h), first, w * h);
                rand_items += w * h - first;
            end
            phase++;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #4_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
